// ===== rtl/core/gha_pkg.sv =====
// Shared types, widths and codes of the generational handle allocator.
package gha_pkg;

  localparam int MAX_ENTITIES  = 1024;
  localparam int VERSION_WIDTH = 12;
  localparam int TABLE_WIDTH   = 8;
  localparam int ROW_WIDTH     = 16;

  localparam int IDX_W  = $clog2(MAX_ENTITIES);
  localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  localparam int IN_VER_LO   = IDX_W;
  localparam int IN_TAB_LO   = IN_VER_LO + VERSION_WIDTH;
  localparam int IN_ROW_LO   = IN_TAB_LO + TABLE_WIDTH;
  localparam int IN_FIELDS_W = IN_ROW_LO + ROW_WIDTH;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_FIELDS_W = IDX_W + VERSION_WIDTH + 1 + TABLE_WIDTH + ROW_WIDTH + 1 + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE   = 2'd0,
    FUNC_DESTROY  = 2'd1,
    FUNC_RELOCATE = 2'd2,
    FUNC_QUERY    = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_STALE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STK,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic                     live;
    logic [VERSION_WIDTH-1:0] version;
    logic                     loc_set;
    logic [TABLE_WIDTH-1:0]   loc_table;
    logic [ROW_WIDTH-1:0]     loc_row;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== rtl/core/generational_handle_allocator.sv =====
// Top level of the generational handle allocator: control, slot and free-stack memories.
//
// One request is taken at a time. Destroy, relocate, query and a create that
// takes a never-used slot go straight to the execute state, where their result
// is registered. A create that reuses a freed slot first passes the free-stack
// state, because the free-stack read must return the index before the slot
// memory can be read at it. The next request is accepted in the cycle after
// the result is registered. The result sits in an output register, so a new
// request is accepted while the previous result still waits to be taken; that
// request then holds in its last cycle until the output register frees.
// No clearing pass runs after reset.
module generational_handle_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // entity_index, entity_version, table_number, row_number
  input  logic [gha_pkg::IN_TDATA_W-1:0] in_tdata,
  // func
  input  logic [gha_pkg::FUNC_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // handle_index, handle_version, present, location_table, location_row,
  // location_set, live_count
  output logic [gha_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [gha_pkg::STAT_W-1:0]     out_tuser
);
  import gha_pkg::*;

  state_t state_r, state_nxt;

  func_t                    req_func_r;
  logic [IDX_W-1:0]         req_idx_r;
  logic [VERSION_WIDTH-1:0] req_ver_r;
  logic [TABLE_WIDTH-1:0]   req_tab_r;
  logic [ROW_WIDTH-1:0]     req_row_r;
  logic [IDX_W-1:0]         slot_idx_r, slot_idx_nxt;

  logic [CNT_W-1:0] free_depth_r, free_depth_nxt;
  logic [CNT_W-1:0] slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0] fd_dec;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [STAT_W-1:0]      out_tuser_r;

  func_t      in_func;
  logic       accept;
  logic       pop_acc;
  logic       out_free;
  logic       exec_go;

  logic             stk_re;
  logic [IDX_W-1:0] stk_raddr;
  logic [IDX_W-1:0] stk_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;

  logic              slot_re;
  logic [IDX_W-1:0]  slot_raddr;
  logic [SLOT_W-1:0] slot_rdata_raw;
  slot_t             slot_rd;
  logic              slot_we;
  logic [IDX_W-1:0]  slot_waddr;
  slot_t             slot_wd;

  status_t                  res_status;
  logic [IDX_W-1:0]         res_idx;
  logic [VERSION_WIDTH-1:0] res_ver;
  logic                     res_present;
  logic [TABLE_WIDTH-1:0]   res_tab;
  logic [ROW_WIDTH-1:0]     res_row;
  logic                     res_set;
  logic [CNT_W-1:0]         res_live_count;
  logic                     is_live;
  logic [VERSION_WIDTH-1:0] ver_bumped;

  assign in_func  = func_t'(in_tuser);
  assign accept   = in_tvalid && in_tready;
  assign pop_acc  = (in_func == FUNC_CREATE) && (free_depth_r != '0);
  assign out_free = !out_valid_r || out_tready;
  assign fd_dec   = free_depth_r - CNT_W'(1);
  assign slot_rd  = slot_t'(slot_rdata_raw);

  gha_ram #(
    .WIDTH(IDX_W),
    .DEPTH(MAX_ENTITIES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(req_idx_r),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  gha_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(MAX_ENTITIES)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wd),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata_raw)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = pop_acc ? S_STK : S_EXEC;
        end
      end
      S_STK: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    stk_re       = 1'b0;
    slot_re      = 1'b0;
    slot_raddr   = in_tdata[IDX_W-1:0];
    exec_go      = 1'b0;
    slot_idx_nxt = slot_idx_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        stk_re    = accept && pop_acc;
        slot_re   = accept && (in_func != FUNC_CREATE);
        if (accept) begin
          slot_idx_nxt = in_tdata[IDX_W-1:0];
        end
      end
      S_STK: begin
        slot_re      = 1'b1;
        slot_raddr   = stk_rdata;
        slot_idx_nxt = stk_rdata;
      end
      S_EXEC: begin
        exec_go = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign stk_raddr = fd_dec[IDX_W-1:0];

  always_comb begin
    res_status     = STAT_OK;
    res_idx        = req_idx_r;
    res_ver        = '0;
    res_present    = 1'b0;
    res_tab        = '0;
    res_row        = '0;
    res_set        = 1'b0;
    free_depth_nxt = free_depth_r;
    slots_used_nxt = slots_used_r;
    slot_we        = 1'b0;
    slot_waddr     = slot_idx_r;
    slot_wd        = slot_rd;
    stk_we         = 1'b0;
    stk_waddr      = free_depth_r[IDX_W-1:0];
    ver_bumped     = req_ver_r + VERSION_WIDTH'(1);
    is_live        = (CNT_W'(req_idx_r) < slots_used_r) && slot_rd.live &&
                     (slot_rd.version == req_ver_r);
    if (req_func_r == FUNC_CREATE) begin
      res_idx = '0;
      if (free_depth_r != '0) begin
        free_depth_nxt = fd_dec;
        slot_we        = exec_go;
        slot_wd.live   = 1'b1;
        res_idx        = slot_idx_r;
        res_ver        = slot_rd.version;
        res_present    = 1'b1;
      end else if (slots_used_r < CNT_W'(MAX_ENTITIES)) begin
        slots_used_nxt = slots_used_r + CNT_W'(1);
        slot_we        = exec_go;
        slot_waddr     = slots_used_r[IDX_W-1:0];
        slot_wd        = '{live: 1'b1, version: '0, loc_set: 1'b0,
                           loc_table: '0, loc_row: '0};
        res_idx        = slots_used_r[IDX_W-1:0];
        res_present    = 1'b1;
      end else begin
        res_status = STAT_FULL;
      end
    end else if (!is_live) begin
      res_status = STAT_STALE;
    end else begin
      res_present = 1'b1;
      case (req_func_r)
        FUNC_DESTROY: begin
          slot_we = exec_go;
          slot_wd = '{live: 1'b0, version: ver_bumped, loc_set: 1'b0,
                      loc_table: '0, loc_row: '0};
          if (free_depth_r < CNT_W'(MAX_ENTITIES)) begin
            stk_we         = exec_go;
            free_depth_nxt = free_depth_r + CNT_W'(1);
          end
          res_ver = ver_bumped;
        end
        FUNC_RELOCATE: begin
          slot_we           = exec_go;
          slot_wd.loc_set   = 1'b1;
          slot_wd.loc_table = req_tab_r;
          slot_wd.loc_row   = req_row_r;
          res_ver           = slot_rd.version;
          res_tab           = req_tab_r;
          res_row           = req_row_r;
          res_set           = 1'b1;
        end
        default: begin
          res_ver = slot_rd.version;
          res_tab = slot_rd.loc_table;
          res_row = slot_rd.loc_row;
          res_set = slot_rd.loc_set;
        end
      endcase
    end
    res_live_count = slots_used_nxt - free_depth_nxt;
    out_tdata_nxt  = OUT_TDATA_W'({res_live_count, res_set, res_row, res_tab,
                                   res_present, res_ver, res_idx});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_depth_r <= '0;
      slots_used_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        free_depth_r <= free_depth_nxt;
        slots_used_r <= slots_used_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_idx_r <= slot_idx_nxt;
    if (accept) begin
      req_func_r <= in_func;
      req_idx_r  <= in_tdata[IDX_W-1:0];
      req_ver_r  <= in_tdata[IN_VER_LO +: VERSION_WIDTH];
      req_tab_r  <= in_tdata[IN_TAB_LO +: TABLE_WIDTH];
      req_row_r  <= in_tdata[IN_ROW_LO +: ROW_WIDTH];
    end
    if (exec_go) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    free_depth_r <= slots_used_r)
    else $error("free stack deeper than the number of allocated slots");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_STK || state_r == S_EXEC))
    else $error("accepted request did not start processing");

  a_stk_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STK |=> state_r == S_EXEC)
    else $error("free-stack read not followed by execution");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result appeared without an executing request");

endmodule

// ===== rtl/core/gha_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
